// ----- sv/mrb_pkg.sv -----
// Shared types and constants of the message ring buffer.
// Used by mrb_seq and message_ring_buffer_top; no dependencies.
package mrb_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAX_ELEM_DEF = 64;

    localparam int LEN_W      = 7;
    localparam int OCC_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG_LEN  = 1'b1;

    localparam logic [OCC_W-1:0] SLOTS_IN_USE_RST = 5'd16;
    localparam logic [LEN_W-1:0] MAX_MSG_LEN_RST  = 7'd64;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_STREAM
    } seq_state_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [OCC_W-1:0] ring_size;
        logic [LEN_W-1:0] length_cap;
    } cfg_t;

endpackage

// ----- sv/message_ring_buffer_top.sv -----
// Top level of the message ring buffer: configuration registers, message
// and slot-length RAMs, and the sequencer. Depends on mrb_pkg, mrb_ram, mrb_seq.
//
// A ring of SLOTS fixed slots, each holding one message of up to MAX_ELEM
// bytes. Every input transfer carries a mode in s_tuser: push one byte
// (s_tlast marks the final byte, which commits the message, or rejects it
// with status full or too long), pop or peek the oldest message, or clear the
// ring. Push, clear and a pop or peek on an empty ring each give one result.
// A pop or peek first reads the slot length from its RAM, then streams
// min(length, read_limit, MAX_ELEM) bytes out of the message RAM, one result
// per cycle while the result side does not stall; the registered RAM read is
// pipelined against the result register. The next input is taken only once
// the pop or peek is through with its last result. A stall on the result
// side holds the stream. Every result reports the occupancy after its step,
// and m_tlast marks the last result of each input. Both RAMs
// come up undefined and need no clearing pass; a read of a slot never written
// (only possible after changing slots_in_use with messages held) returns
// arbitrary data. Write configuration only while the block is idle.
module message_ring_buffer_top #(
    parameter int SLOTS    = mrb_pkg::SLOTS_DEF,
    parameter int MAX_ELEM = mrb_pkg::MAX_ELEM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // push_byte[7:0], read_limit[14:8], zero
    input  logic                              s_tlast,  // push_last
    input  logic [1:0]                        s_tuser,  // mode[1:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // out_byte[7:0], message_length[14:8],
                                                        // occupancy[19:15], zero
    output logic                              m_tlast,  // last_result
    output logic [2:0]                        m_tuser   // status[1:0], byte_valid[2]
);

    import mrb_pkg::*;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ELEM_W  = (MAX_ELEM > 1) ? $clog2(MAX_ELEM) : 1;
    localparam int DATA_DEPTH = SLOTS * (2 ** ELEM_W);

    logic [OCC_W-1:0] slots_in_use_reg;
    logic [LEN_W-1:0] max_msg_len_reg;
    cfg_t             cfg;

    // Configuration: always ready, write by index, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            max_msg_len_reg  <= MAX_MSG_LEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[OCC_W-1:0];
                CFG_MAX_MSG_LEN:  max_msg_len_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the registers to the ranges the ring supports
    always_comb begin
        if (slots_in_use_reg == '0) begin
            cfg.ring_size = OCC_W'(1);
        end else if (int'(slots_in_use_reg) > SLOTS) begin
            cfg.ring_size = OCC_W'(SLOTS);
        end else begin
            cfg.ring_size = slots_in_use_reg;
        end
        if (max_msg_len_reg == '0) begin
            cfg.length_cap = LEN_W'(1);
        end else if (int'(max_msg_len_reg) > MAX_ELEM) begin
            cfg.length_cap = LEN_W'(MAX_ELEM);
        end else begin
            cfg.length_cap = max_msg_len_reg;
        end
    end

    logic                     data_we, data_re;
    logic [SLOT_W+ELEM_W-1:0] data_waddr, data_raddr;
    logic [BYTE_W-1:0]        data_wdata, data_rdata;
    logic                     len_we, len_re;
    logic [SLOT_W-1:0]        len_waddr, len_raddr;
    logic [LEN_W-1:0]         len_wdata, len_rdata;

    status_t                  res_status;
    logic [BYTE_W-1:0]        res_byte;
    logic                     res_byte_valid;
    logic [LEN_W-1:0]         res_length;
    logic [OCC_W-1:0]         res_occupancy;

    mrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_message_store (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    mrb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_slot_length (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    mrb_seq #(
        .SLOTS    (SLOTS),
        .MAX_ELEM (MAX_ELEM),
        .SLOT_W   (SLOT_W),
        .ELEM_W   (ELEM_W)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_mode        (mode_t'(s_tuser)),
        .in_push_byte   (s_tdata[7:0]),
        .in_push_last   (s_tlast),
        .in_read_limit  (s_tdata[14:8]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (res_status),
        .out_byte       (res_byte),
        .out_byte_valid (res_byte_valid),
        .out_length     (res_length),
        .out_occupancy  (res_occupancy),
        .out_last       (m_tlast),
        .data_we        (data_we),
        .data_waddr     (data_waddr),
        .data_wdata     (data_wdata),
        .data_re        (data_re),
        .data_raddr     (data_raddr),
        .data_rdata     (data_rdata),
        .len_we         (len_we),
        .len_waddr      (len_waddr),
        .len_wdata      (len_wdata),
        .len_re         (len_re),
        .len_raddr      (len_raddr),
        .len_rdata      (len_rdata)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {4'b0000, res_occupancy, res_length, res_byte};
    assign m_tuser = {res_byte_valid, res_status};

endmodule

// ----- sv/mrb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Hold read data while no read is issued
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/mrb_seq.sv -----
// Sequencer of the message ring buffer: ring pointers, push assembly,
// pop/peek streaming and the result register. Depends on mrb_pkg.
module mrb_seq #(
    parameter int SLOTS    = mrb_pkg::SLOTS_DEF,
    parameter int MAX_ELEM = mrb_pkg::MAX_ELEM_DEF,
    parameter int SLOT_W   = $clog2(SLOTS),
    parameter int ELEM_W   = (MAX_ELEM > 1) ? $clog2(MAX_ELEM) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrb_pkg::cfg_t                 cfg,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mrb_pkg::mode_t                in_mode,
    input  logic [mrb_pkg::BYTE_W-1:0]    in_push_byte,
    input  logic                          in_push_last,
    input  logic [mrb_pkg::LEN_W-1:0]     in_read_limit,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output mrb_pkg::status_t              out_status,
    output logic [mrb_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_byte_valid,
    output logic [mrb_pkg::LEN_W-1:0]     out_length,
    output logic [mrb_pkg::OCC_W-1:0]     out_occupancy,
    output logic                          out_last,
    // message store RAM
    output logic                          data_we,
    output logic [SLOT_W+ELEM_W-1:0]      data_waddr,
    output logic [mrb_pkg::BYTE_W-1:0]    data_wdata,
    output logic                          data_re,
    output logic [SLOT_W+ELEM_W-1:0]      data_raddr,
    input  logic [mrb_pkg::BYTE_W-1:0]    data_rdata,
    // slot length RAM
    output logic                          len_we,
    output logic [SLOT_W-1:0]             len_waddr,
    output logic [mrb_pkg::LEN_W-1:0]     len_wdata,
    output logic                          len_re,
    output logic [SLOT_W-1:0]             len_raddr,
    input  logic [mrb_pkg::LEN_W-1:0]     len_rdata
);

    import mrb_pkg::*;

    localparam int CW = ((SLOT_W > OCC_W) ? SLOT_W : OCC_W) + 1;
    localparam logic [LEN_W-1:0] MAX_ELEM_L = LEN_W'(MAX_ELEM);

    seq_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0] stream_slot_reg, stream_slot_next;
    logic [OCC_W-1:0]  held_reg, held_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic              too_long_reg, too_long_next;
    logic              blocked_reg, blocked_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [LEN_W-1:0]  msg_len_reg, msg_len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  issue_reg, issue_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              full;
    logic [LEN_W-1:0]  n_lim;
    logic [LEN_W-1:0]  n_bytes;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [OCC_W-1:0] ring);
        logic [CW-1:0] inc;
        inc = CW'(s) + CW'(1);
        return (inc >= CW'(ring)) ? '0 : inc[SLOT_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = held_reg >= cfg.ring_size;

    // Bytes to stream: min(length, limit, MAX_ELEM)
    assign n_lim   = (len_rdata < limit_reg) ? len_rdata : limit_reg;
    assign n_bytes = (n_lim > MAX_ELEM_L) ? MAX_ELEM_L : n_lim;

    always_comb begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        stream_slot_next = stream_slot_reg;
        held_next        = held_reg;
        bytes_next       = bytes_reg;
        too_long_next    = too_long_reg;
        blocked_next     = blocked_reg;
        limit_next       = limit_reg;
        msg_len_next     = msg_len_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_byte_next    = out_byte_reg;
        out_bvalid_next  = out_bvalid_reg;
        out_len_next     = out_len_reg;
        out_occ_next     = out_occ_reg;
        out_last_next    = out_last_reg;

        data_we    = 1'b0;
        data_waddr = {write_slot_reg, bytes_reg[ELEM_W-1:0]};
        data_wdata = in_push_byte;
        data_re    = 1'b0;
        data_raddr = {stream_slot_reg, issue_reg[ELEM_W-1:0]};
        len_we     = 1'b0;
        len_waddr  = write_slot_reg;
        len_wdata  = bytes_reg;
        len_re     = 1'b0;
        len_raddr  = read_slot_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_byte_next   = '0;
                    out_bvalid_next = 1'b0;
                    out_len_next    = '0;
                    out_last_next   = 1'b1;
                    case (in_mode)
                        MODE_PUSH: begin
                            blocked_next = blocked_reg || full;
                            if (bytes_reg >= MAX_ELEM_L) begin
                                too_long_next = 1'b1;
                            end else begin
                                data_we    = !full;
                                bytes_next = bytes_reg + LEN_W'(1);
                            end
                            if (in_push_last) begin
                                if (full || blocked_next) begin
                                    out_status_next = STAT_FULL;
                                end else if (too_long_next || bytes_next > cfg.length_cap) begin
                                    out_status_next = STAT_TOO_LONG;
                                end else begin
                                    // Commit the message to the write slot
                                    len_we          = 1'b1;
                                    len_wdata       = bytes_next;
                                    write_slot_next = next_slot(write_slot_reg, cfg.ring_size);
                                    held_next       = held_reg + OCC_W'(1);
                                end
                                bytes_next    = '0;
                                too_long_next = 1'b0;
                                blocked_next  = 1'b0;
                            end
                            out_occ_next = held_next;
                        end
                        MODE_CLEAR: begin
                            write_slot_next = '0;
                            read_slot_next  = '0;
                            held_next       = '0;
                            bytes_next      = '0;
                            too_long_next   = 1'b0;
                            blocked_next    = 1'b0;
                            out_occ_next    = '0;
                        end
                        MODE_POP, MODE_PEEK: begin
                            if (held_reg == '0) begin
                                out_status_next = STAT_EMPTY;
                                out_occ_next    = held_reg;
                            end else begin
                                // Fetch the length; the result waits for it
                                out_valid_next   = out_valid_reg && !out_ready;
                                len_re           = 1'b1;
                                stream_slot_next = read_slot_reg;
                                limit_next       = in_read_limit;
                                if (in_mode == MODE_POP) begin
                                    read_slot_next = next_slot(read_slot_reg, cfg.ring_size);
                                    held_next      = held_reg - OCC_W'(1);
                                end
                                state_next = ST_LEN;
                            end
                        end
                        default: begin
                            out_occ_next = held_reg;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                msg_len_next = len_rdata;
                if (n_bytes == '0) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_OK;
                        out_byte_next   = '0;
                        out_bvalid_next = 1'b0;
                        out_len_next    = len_rdata;
                        out_occ_next    = held_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    // Issue the first byte read
                    data_re    = 1'b1;
                    data_raddr = {stream_slot_reg, {ELEM_W{1'b0}}};
                    count_next = n_bytes;
                    issue_next = LEN_W'(1);
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM: begin
                // Read data is pending here; move it out when the register frees
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_byte_next   = data_rdata;
                    out_bvalid_next = 1'b1;
                    out_len_next    = msg_len_reg;
                    out_occ_next    = held_reg;
                    out_last_next   = (issue_reg == count_reg);
                    if (issue_reg < count_reg) begin
                        data_re    = 1'b1;
                        issue_next = issue_reg + LEN_W'(1);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            held_reg       <= '0;
            bytes_reg      <= '0;
            too_long_reg   <= 1'b0;
            blocked_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            held_reg       <= held_next;
            bytes_reg      <= bytes_next;
            too_long_reg   <= too_long_next;
            blocked_reg    <= blocked_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stream_slot_reg <= stream_slot_next;
        limit_reg       <= limit_next;
        msg_len_reg     <= msg_len_next;
        count_reg       <= count_next;
        issue_reg       <= issue_next;
        out_status_reg  <= out_status_next;
        out_byte_reg    <= out_byte_next;
        out_bvalid_reg  <= out_bvalid_next;
        out_len_reg     <= out_len_next;
        out_occ_reg     <= out_occ_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_bvalid_reg;
    assign out_length     = out_len_reg;
    assign out_occupancy  = out_occ_reg;
    assign out_last       = out_last_reg;

endmodule
